FILE: src/gimbal_lock_and_index_model_macros.svh
// Assertion macros shared by the gimbal lock and index model RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef GIMBAL_LOCK_AND_INDEX_MODEL_MACROS_SVH
`define GIMBAL_LOCK_AND_INDEX_MODEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gimbal model assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GLM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gimbal model assertion failed");

`endif

FILE: src/glm_pkg.sv
`default_nettype none
package glm_pkg;

	localparam int ANGLE_FRAC_BITS = 8;
	localparam int ANG_ONE         = 1 << ANGLE_FRAC_BITS;

	localparam int ANG_W  = 17;
	localparam int BANG_W = 16;

	localparam logic signed [ANG_W-1:0] ALPHA_MAX = ANG_W'(206 * ANG_ONE);
	localparam logic signed [ANG_W-1:0] ALPHA_MIN = ANG_W'(-154 * ANG_ONE);
	localparam logic signed [ANG_W-1:0] BETA_MAX  = ANG_W'(85 * ANG_ONE);
	localparam logic signed [ANG_W-1:0] BETA_MIN  = ANG_W'(-75 * ANG_ONE);

	localparam logic signed [ANG_W-1:0]  ALPHA_RESET = ANG_W'((1243 * ANG_ONE + 5) / 10);
	localparam logic signed [BANG_W-1:0] BETA_RESET  = BANG_W'(-(55 * ANG_ONE) / 2);

	localparam logic [16:0] PIN_FULL = 17'h10000;
	localparam logic [16:0] PIN_HALF = 17'h08000;

	localparam logic [15:0] SPEED_RESET = 16'd16384;

	localparam logic [1:0] DRV_OFF    = 2'd0;
	localparam logic [1:0] DRV_LOCK   = 2'd1;
	localparam logic [1:0] DRV_UNLOCK = 2'd2;

	localparam logic [1:0] CFG_PIN1_SPEED = 2'd0;
	localparam logic [1:0] CFG_PIN2_SPEED = 2'd1;
	localparam logic [1:0] CFG_ALPHA_IDX  = 2'd2;
	localparam logic [1:0] CFG_BETA_IDX   = 2'd3;

	typedef struct packed {
		logic [1:0]         lock_drive;
		logic signed [15:0] alpha_rate;
		logic signed [15:0] beta_rate;
		logic [15:0]        tick_dt;
	} tick_t;

	typedef struct packed {
		logic signed [ANG_W-1:0]  alpha_angle;
		logic signed [BANG_W-1:0] beta_angle;
		logic                     alpha_index_pulse;
		logic                     beta_index_pulse;
		logic                     stow_enable;
	} status_t;

	typedef struct packed {
		logic [16:0] pin1;
		logic [16:0] pin2;
		logic        free_move;
		logic        stow;
	} pin_state_t;

endpackage
`default_nettype wire

FILE: src/glm_tick_if.sv
`default_nettype none
interface glm_tick_if;
	import glm_pkg::*;

	logic  valid;
	logic  ready;
	tick_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/glm_status_if.sv
`default_nettype none
interface glm_status_if;
	import glm_pkg::*;

	logic    valid;
	logic    ready;
	status_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/glm_pin.sv
`default_nettype none
module glm_pin (
	input  wire logic [16:0]          pin1,
	input  wire logic [16:0]          pin2,
	input  wire logic [15:0]          pin1_speed,
	input  wire logic [15:0]          pin2_speed,
	input  wire logic [1:0]           drive,
	input  wire logic [15:0]          dt,
	output glm_pkg::pin_state_t       nxt
);
	import glm_pkg::*;

	logic [31:0] prod1, prod2;
	logic [15:0] d1, d2;
	logic [17:0] up1, up2;
	logic [16:0] sat_up1, sat_up2, dn1, dn2;
	logic [16:0] n1, n2;

	assign prod1 = pin1_speed * dt;
	assign prod2 = pin2_speed * dt;
	assign d1    = prod1[31:16];
	assign d2    = prod2[31:16];

	assign up1     = {1'b0, pin1} + {2'b00, d1};
	assign up2     = {1'b0, pin2} + {2'b00, d2};
	assign sat_up1 = (up1 > {1'b0, PIN_FULL}) ? PIN_FULL : up1[16:0];
	assign sat_up2 = (up2 > {1'b0, PIN_FULL}) ? PIN_FULL : up2[16:0];
	assign dn1     = ({1'b0, d1} >= pin1) ? 17'd0 : pin1 - {1'b0, d1};
	assign dn2     = ({1'b0, d2} >= pin2) ? 17'd0 : pin2 - {1'b0, d2};

	always_comb begin
		n1 = pin1;
		n2 = pin2;
		case (drive)
			DRV_LOCK: begin
				if (pin1 < PIN_FULL) begin
					n1 = sat_up1;
				end else begin
					n2 = sat_up2;
				end
			end
			DRV_UNLOCK: begin
				n1 = dn1;
				n2 = dn2;
			end
			default: begin
				n1 = pin1;
				n2 = pin2;
			end
		endcase
	end

	assign nxt.pin1      = n1;
	assign nxt.pin2      = n2;
	assign nxt.free_move = (n1 < PIN_HALF) || (n2 < PIN_HALF);
	assign nxt.stow      = (n2 == PIN_FULL);
endmodule
`default_nettype wire

FILE: src/glm_axis.sv
`default_nettype none
module glm_axis (
	input  wire logic signed [16:0] pos,
	input  wire logic signed [15:0] rate,
	input  wire logic [15:0]        dt,
	input  wire logic               move,
	input  wire logic signed [16:0] lo,
	input  wire logic signed [16:0] hi,
	input  wire logic signed [16:0] idx,
	output logic signed [16:0]      nxt,
	output logic                    pulse
);
	import glm_pkg::*;

	logic signed [32:0] prod;
	logic signed [16:0] step;
	logic signed [18:0] sum;
	logic signed [18:0] lo_x, hi_x;

	assign prod = $signed(rate) * $signed({1'b0, dt});
	assign step = prod[32:16];
	assign sum  = move ? ({{2{pos[16]}}, pos} + {{2{step[16]}}, step})
	                   : {{2{pos[16]}}, pos};
	assign lo_x = {{2{lo[16]}}, lo};
	assign hi_x = {{2{hi[16]}}, hi};

	always_comb begin
		if (sum > hi_x) begin
			nxt = hi;
		end else if (sum < lo_x) begin
			nxt = lo;
		end else begin
			nxt = sum[16:0];
		end
	end

	assign pulse = ((nxt >= idx) && (idx >= pos)) || ((nxt <= idx) && (idx <= pos));
endmodule
`default_nettype wire

FILE: src/gimbal_lock_and_index_model.sv
// Channel   Modport  Beat
// tick      sink     lock_drive, alpha_rate, beta_rate, tick_dt
// status    source   alpha_angle, beta_angle, alpha/beta_index_pulse, stow_enable
// cfg       write    cfg_we, cfg_idx, cfg_wdata
//
// A tick beat is registered in tick_s1 and processed combinationally; its status
// beat is registered in status_s2, from which it is presented on status.
// One beat per cycle is sustained while status is ready.
// The cycle is set by the pin step multiply, pin saturation and angle clamp.
// arst_n returns the pins to fully locked, the angles to their stowed values
// and the speed and index registers to their defaults.
// A stalled status beat holds the processing stage, which then backs up tick.
`default_nettype none
`include "gimbal_lock_and_index_model_macros.svh"
module gimbal_lock_and_index_model (
	input  wire logic        clk,
	input  wire logic        arst_n,
	glm_tick_if.sink         tick,
	glm_status_if.source     status,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [16:0] cfg_wdata
);
	import glm_pkg::*;

	logic [15:0]              pin1_speed_q, pin2_speed_q;
	logic signed [ANG_W-1:0]  alpha_idx_q;
	logic signed [BANG_W-1:0] beta_idx_q;

	logic signed [ANG_W-1:0]  alpha_q;
	logic signed [BANG_W-1:0] beta_q;
	logic [16:0]              pin1_q, pin2_q;

	tick_t   tick_s1;
	logic    vld_s1;
	status_t status_s2;
	logic    vld_s2;

	logic       advance;
	pin_state_t pin_nxt;
	logic signed [16:0] alpha_nxt, beta_nxt17;
	logic signed [16:0] beta_pos17;
	logic       alpha_pulse, beta_pulse;

	assign advance    = !vld_s2 || status.ready;
	assign tick.ready = !vld_s1 || advance;
	assign beta_pos17 = {beta_q[BANG_W-1], beta_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin1_speed_q <= SPEED_RESET;
			pin2_speed_q <= SPEED_RESET;
			alpha_idx_q  <= '0;
			beta_idx_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PIN1_SPEED: pin1_speed_q <= cfg_wdata[15:0];
				CFG_PIN2_SPEED: pin2_speed_q <= cfg_wdata[15:0];
				CFG_ALPHA_IDX:  alpha_idx_q  <= cfg_wdata;
				CFG_BETA_IDX:   beta_idx_q   <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (tick.ready) begin
			vld_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1 <= tick.payload;
		end
	end

	glm_pin u_pin (
		.pin1       (pin1_q),
		.pin2       (pin2_q),
		.pin1_speed (pin1_speed_q),
		.pin2_speed (pin2_speed_q),
		.drive      (tick_s1.lock_drive),
		.dt         (tick_s1.tick_dt),
		.nxt        (pin_nxt)
	);

	glm_axis u_alpha (
		.pos   (alpha_q),
		.rate  (tick_s1.alpha_rate),
		.dt    (tick_s1.tick_dt),
		.move  (pin_nxt.free_move),
		.lo    (ALPHA_MIN),
		.hi    (ALPHA_MAX),
		.idx   (alpha_idx_q),
		.nxt   (alpha_nxt),
		.pulse (alpha_pulse)
	);

	glm_axis u_beta (
		.pos   (beta_pos17),
		.rate  (tick_s1.beta_rate),
		.dt    (tick_s1.tick_dt),
		.move  (pin_nxt.free_move),
		.lo    (BETA_MIN),
		.hi    (BETA_MAX),
		.idx   ({beta_idx_q[BANG_W-1], beta_idx_q}),
		.nxt   (beta_nxt17),
		.pulse (beta_pulse)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			beta_q  <= BETA_RESET;
			pin1_q  <= PIN_FULL;
			pin2_q  <= PIN_FULL;
			vld_s2  <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				alpha_q <= alpha_nxt;
				beta_q  <= beta_nxt17[BANG_W-1:0];
				pin1_q  <= pin_nxt.pin1;
				pin2_q  <= pin_nxt.pin2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			status_s2.alpha_angle       <= alpha_nxt;
			status_s2.beta_angle        <= beta_nxt17[BANG_W-1:0];
			status_s2.alpha_index_pulse <= alpha_pulse;
			status_s2.beta_index_pulse  <= beta_pulse;
			status_s2.stow_enable       <= pin_nxt.stow;
		end
	end

	assign status.valid   = vld_s2;
	assign status.payload = status_s2;

	`GLM_ASSERT_IMP(a_pins_in_range, 1'b1, (pin1_q <= PIN_FULL) && (pin2_q <= PIN_FULL))
	`GLM_ASSERT_IMP(a_alpha_in_stops, 1'b1, (alpha_q >= ALPHA_MIN) && (alpha_q <= ALPHA_MAX))
	`GLM_ASSERT_IMP(a_beta_in_stops, 1'b1, (beta_pos17 >= BETA_MIN) && (beta_pos17 <= BETA_MAX))
	`GLM_ASSERT_NXT(a_state_holds_on_stall, vld_s2 && !status.ready, $stable(alpha_q) && $stable(beta_q) && $stable(pin1_q) && $stable(pin2_q))
	`GLM_ASSERT_IMP(a_stow_matches_pin2, vld_s2, status_s2.stow_enable == (pin2_q == PIN_FULL))
	`GLM_ASSERT_IMP(a_angle_matches_state, vld_s2, (status_s2.alpha_angle == alpha_q) && (status_s2.beta_angle == beta_q))
endmodule
`default_nettype wire
